@@ hw/rtl/irclt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// irclt_pkg - shared types and constants of the IRC line tokenizer
// Word formats, line state, phase/class/role/command codes, keyword table and
// small per-byte helper functions.
// ----------------------------------------------------------------------------
package irclt_pkg;

    localparam int ID_W    = 32;   // width of the id accumulator
    localparam int CONN_W  = 32;   // width of the reported id
    localparam int CMD_W   = 56;   // first seven command bytes
    localparam int CLEN_W  = 4;
    localparam int NUM_W   = 10;
    localparam int PARAM_W = 4;
    localparam int KW_COUNT = 10;

    localparam logic [PARAM_W-1:0] MAX_PARAMS = 4'd15;

    // line phases
    localparam logic [2:0] PH_START      = 3'd0;
    localparam logic [2:0] PH_CID_S      = 3'd1;
    localparam logic [2:0] PH_CID_DIGITS = 3'd2;
    localparam logic [2:0] PH_CID_SPACE  = 3'd3;
    localparam logic [2:0] PH_PREFIX     = 3'd4;
    localparam logic [2:0] PH_COMMAND    = 3'd5;
    localparam logic [2:0] PH_PARAMS     = 3'd6;
    localparam logic [2:0] PH_TEXT       = 3'd7;

    // byte classes
    localparam logic [2:0] CLS_NONE   = 3'd0;
    localparam logic [2:0] CLS_PREFIX = 3'd1;
    localparam logic [2:0] CLS_CMD    = 3'd2;
    localparam logic [2:0] CLS_PARAM  = 3'd3;
    localparam logic [2:0] CLS_TEXT   = 3'd4;

    // roles of a closed segment
    localparam logic [2:0] ROLE_NONE  = 3'd0;
    localparam logic [2:0] ROLE_NICK  = 3'd1;
    localparam logic [2:0] ROLE_REAL  = 3'd2;
    localparam logic [2:0] ROLE_HOST  = 3'd3;
    localparam logic [2:0] ROLE_CMD   = 3'd4;
    localparam logic [2:0] ROLE_PARAM = 3'd5;
    localparam logic [2:0] ROLE_TEXT  = 3'd6;

    // command types; keywords follow CT_JOIN in table order
    localparam logic [3:0] CT_UNKNOWN = 4'd0;
    localparam logic [3:0] CT_NUMERIC = 4'd1;
    localparam logic [3:0] CT_JOIN    = 4'd2;

    // characters
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // keywords, first character in the low byte, zero padded
    localparam logic [CMD_W-1:0] KW_TEXT [KW_COUNT] = '{
        56'h0000004E494F4A,   // JOIN
        56'h0000004B43494B,   // KICK
        56'h00000045444F4D,   // MODE
        56'h0000004B43494E,   // NICK
        56'h00454349544F4E,   // NOTICE
        56'h00000054524150,   // PART
        56'h000000474E4950,   // PING
        56'h47534D56495250,   // PRIVMSG
        56'h00000054495551,   // QUIT
        56'h00004349504F54    // TOPIC
    };
    localparam logic [CLEN_W-1:0] KW_LEN [KW_COUNT] = '{
        4'd4, 4'd4, 4'd4, 4'd4, 4'd6, 4'd4, 4'd4, 4'd7, 4'd4, 4'd5
    };

    typedef struct packed {
        logic [7:0] line_byte;
        logic       line_end;
    } line_word_t;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic [2:0]         byte_class;
        logic               segment_end;
        logic [2:0]         segment_role;
        logic [PARAM_W-1:0] param_index;
        logic               line_done;
        logic [3:0]         command_type;
        logic [NUM_W-1:0]   numeric_code;
        logic [CONN_W-1:0]  conn_id;
        logic [PARAM_W-1:0] param_count;
        logic               param_overflow;
    } tag_word_t;

    typedef struct packed {
        logic [2:0]         phase;
        logic [ID_W-1:0]    id_accum;
        logic [CMD_W-1:0]   cmd_bytes;
        logic [CLEN_W-1:0]  cmd_len;
        logic [NUM_W-1:0]   num_accum;
        logic [1:0]         digit_count;
        logic [PARAM_W-1:0] params_kept;
        logic               at_param_start;
        logic               overflowed;
    } line_state_t;

    localparam line_state_t LINE_CLEAR = '{
        phase:          PH_START,
        id_accum:       '0,
        cmd_bytes:      '0,
        cmd_len:        '0,
        num_accum:      '0,
        digit_count:    '0,
        params_kept:    '0,
        at_param_start: 1'b1,
        overflowed:     1'b0
    };

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= 8'd9) && (b <= 8'd13));
    endfunction

    // id * 10 + digit, saturating at all ones
    function automatic logic [ID_W-1:0] id_step(input logic [ID_W-1:0] id,
                                                input logic [3:0] d);
        logic [ID_W+3:0] w;
        w = ({4'b0, id} << 3) + ({4'b0, id} << 1) + (ID_W+4)'(d);
        if (w[ID_W+3:ID_W] != 4'd0)
            return '1;
        else
            return w[ID_W-1:0];
    endfunction

    // append one command byte, tracking the leading numeric digits
    function automatic line_state_t store_cmd(input line_state_t s, input logic [7:0] b);
        line_state_t     r;
        logic [NUM_W+3:0] t;
        r = s;
        if (({2'b0, s.digit_count} == s.cmd_len) && (s.digit_count != 2'd3)
            && is_digit(b))
        begin
            t = ({4'b0, s.num_accum} << 3) + ({4'b0, s.num_accum} << 1)
                + (NUM_W+4)'(b[3:0]);
            r.num_accum   = t[NUM_W-1:0];
            r.digit_count = s.digit_count + 2'd1;
        end
        if (s.cmd_len < 4'd7)
            r.cmd_bytes = s.cmd_bytes | ({{(CMD_W-8){1'b0}}, b} << {s.cmd_len[2:0], 3'b000});
        if (s.cmd_len != 4'd15)
            r.cmd_len = s.cmd_len + 4'd1;
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/irclt_kind.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// irclt_kind - command classifier
// Maps the stored command bytes and length to unknown, numeric or one of the
// ten keywords.
// ----------------------------------------------------------------------------
module irclt_kind (
    input  wire logic [irclt_pkg::CMD_W-1:0]  cmd_bytes,
    input  wire logic [irclt_pkg::CLEN_W-1:0] cmd_len,
    output logic [3:0]                        command_type
);
    import irclt_pkg::*;

    logic [3:0] kw_type;

    // keywords are distinct, so at most one compare hits
    always_comb
    begin
        kw_type = CT_UNKNOWN;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if ((cmd_len == KW_LEN[k]) && (cmd_bytes == KW_TEXT[k]))
                kw_type = CT_JOIN + 4'(k);
        end
    end

    always_comb
    begin
        priority if (cmd_len == '0)
            command_type = CT_UNKNOWN;
        else if (is_digit(cmd_bytes[7:0]))
            command_type = CT_NUMERIC;
        else
            command_type = kw_type;
    end

endmodule
`default_nettype wire

@@ hw/rtl/irclt_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// irclt_step - per-byte tokenizer step
// From the current line state and one input word, forms the tagged result
// word and the line state that follows.
// ----------------------------------------------------------------------------
module irclt_step (
    input  wire irclt_pkg::line_state_t cur_state,
    input  wire irclt_pkg::line_word_t  din,
    output irclt_pkg::line_state_t      next_state,
    output irclt_pkg::tag_word_t        dout
);
    import irclt_pkg::*;

    line_state_t        s_upd;
    line_state_t        s_fin;
    logic [2:0]         cls;
    logic               seg;
    logic [2:0]         role;
    logic [PARAM_W-1:0] pidx;
    logic               seg_fin;
    logic [2:0]         role_fin;
    logic [PARAM_W-1:0] pidx_fin;
    logic [3:0]         kind;
    logic [7:0]         b;
    logic               do_begin;
    logic               do_cmd;

    assign b = din.line_byte;

    always_comb
    begin
        s_upd    = cur_state;
        cls      = CLS_NONE;
        seg      = 1'b0;
        role     = ROLE_NONE;
        pidx     = '0;
        do_begin = 1'b0;
        do_cmd   = 1'b0;

        unique case (cur_state.phase)
            PH_START:
            begin
                if (b == CH_S)
                    s_upd.phase = PH_CID_S;
                else
                    do_begin = 1'b1;
            end
            PH_CID_S:
            begin
                if (is_digit(b))
                begin
                    s_upd.id_accum = id_step(cur_state.id_accum, b[3:0]);
                    s_upd.phase    = PH_CID_DIGITS;
                end
                else
                begin
                    // no id after all: the S opens the command
                    s_upd       = store_cmd(cur_state, CH_S);
                    s_upd.phase = PH_COMMAND;
                    do_cmd      = 1'b1;
                end
            end
            PH_CID_DIGITS:
            begin
                priority if (is_digit(b))
                    s_upd.id_accum = id_step(cur_state.id_accum, b[3:0]);
                else if (is_ws(b))
                    s_upd.phase = PH_CID_SPACE;
                else
                    do_begin = 1'b1;
            end
            PH_CID_SPACE:
            begin
                if (!is_ws(b))
                    do_begin = 1'b1;
            end
            PH_PREFIX:
            begin
                priority if (b == CH_BANG)
                begin
                    seg  = 1'b1;
                    role = ROLE_NICK;
                end
                else if (b == CH_AT)
                begin
                    seg  = 1'b1;
                    role = ROLE_REAL;
                end
                else if (b == CH_SPACE)
                begin
                    seg         = 1'b1;
                    role        = ROLE_HOST;
                    s_upd.phase = PH_COMMAND;
                end
                else
                    cls = CLS_PREFIX;
            end
            PH_COMMAND:
                do_cmd = 1'b1;
            PH_PARAMS:
            begin
                priority if (cur_state.overflowed)
                    cls = CLS_NONE;
                else if (cur_state.at_param_start && (b == CH_COLON))
                    s_upd.phase = PH_TEXT;
                else if (cur_state.at_param_start && (cur_state.params_kept >= MAX_PARAMS))
                    s_upd.overflowed = 1'b1;
                else if (b == CH_SPACE)
                begin
                    seg                  = 1'b1;
                    role                 = ROLE_PARAM;
                    pidx                 = cur_state.params_kept;
                    s_upd.params_kept    = cur_state.params_kept + 4'd1;
                    s_upd.at_param_start = 1'b1;
                end
                else
                begin
                    cls                  = CLS_PARAM;
                    pidx                 = cur_state.params_kept;
                    s_upd.at_param_start = 1'b0;
                end
            end
            default:
                cls = CLS_TEXT;
        endcase

        if (do_begin)
        begin
            if (b == CH_COLON)
                s_upd.phase = PH_PREFIX;
            else
            begin
                s_upd.phase = PH_COMMAND;
                do_cmd      = 1'b1;
            end
        end

        if (do_cmd)
        begin
            if (b == CH_SPACE)
            begin
                seg                  = 1'b1;
                role                 = ROLE_CMD;
                s_upd.phase          = PH_PARAMS;
                s_upd.at_param_start = 1'b1;
            end
            else
            begin
                cls   = CLS_CMD;
                s_upd = store_cmd(s_upd, b);
            end
        end
    end

    irclt_kind u_kind (
        .cmd_bytes    (s_upd.cmd_bytes),
        .cmd_len      (s_upd.cmd_len),
        .command_type (kind)
    );

    // line end closes an open command, parameter or trailing text segment
    always_comb
    begin
        s_fin    = s_upd;
        seg_fin  = seg;
        role_fin = role;
        pidx_fin = pidx;
        if (din.line_end)
        begin
            priority if ((s_upd.phase == PH_COMMAND) && !seg)
            begin
                seg_fin  = 1'b1;
                role_fin = ROLE_CMD;
            end
            else if ((s_upd.phase == PH_PARAMS) && !s_upd.overflowed
                     && !s_upd.at_param_start)
            begin
                seg_fin           = 1'b1;
                role_fin          = ROLE_PARAM;
                pidx_fin          = s_upd.params_kept;
                s_fin.params_kept = s_upd.params_kept + 4'd1;
            end
            else if (s_upd.phase == PH_TEXT)
            begin
                seg_fin  = 1'b1;
                role_fin = ROLE_TEXT;
            end
            else
            begin
            end
        end
    end

    always_comb
    begin
        dout                = '0;
        dout.out_byte       = b;
        dout.byte_class     = cls;
        dout.segment_end    = seg_fin;
        dout.segment_role   = role_fin;
        dout.param_index    = pidx_fin;
        if (din.line_end)
        begin
            dout.line_done      = 1'b1;
            dout.command_type   = kind;
            dout.numeric_code   = (kind == CT_NUMERIC) ? s_upd.num_accum : '0;
            dout.conn_id        = CONN_W'(s_upd.id_accum);
            dout.param_count    = s_fin.params_kept;
            dout.param_overflow = s_upd.overflowed;
        end
        next_state = din.line_end ? LINE_CLEAR : s_fin;
    end

endmodule
`default_nettype wire

@@ hw/rtl/irc_line_tokenizer_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// irc_line_tokenizer_core - IRC message line tokenizer
// Tags each byte of a message line and reports command, id and parameter
// summary on the last byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel line_valid/line_stall/line_data carries one line byte per
//   word with a last-byte mark. Output channel tag_valid/tag_stall/tag_data
//   returns exactly one tagged word per input word, in order.
//   A word accepted is held in the input register, passed through a single
//   combinational step that also updates the line state, and held in the
//   result register that drives tag_data. Throughput: one word per cycle
//   while tag_stall does not hold a waiting result.
//   The summary fields are valid only on the word with line_done set; the
//   line state then returns to line start.
//   Reset empties both registers and puts the line state at line start.
//   While tag_stall holds a waiting result, the result stays put; the input
//   register still takes one more word, and line_stall rises only when both
//   registers are full.
// ----------------------------------------------------------------------------
module irc_line_tokenizer_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 line_valid,
    output logic                      line_stall,
    input  wire irclt_pkg::line_word_t line_data,
    output logic                      tag_valid,
    input  wire logic                 tag_stall,
    output irclt_pkg::tag_word_t      tag_data
);
    import irclt_pkg::*;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    line_word_t  s1_data_reg;
    line_word_t  s1_data_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    tag_word_t   out_data_reg;
    tag_word_t   out_data_next;
    line_state_t state_reg;
    line_state_t state_next;
    line_state_t step_state;
    tag_word_t   step_result;
    logic        advance;

    irclt_step u_step (
        .cur_state  (state_reg),
        .din        (s1_data_reg),
        .next_state (step_state),
        .dout       (step_result)
    );

    assign advance    = s1_valid_reg && (!out_valid_reg || !tag_stall);
    assign line_stall = s1_valid_reg && out_valid_reg && tag_stall;
    assign tag_valid  = out_valid_reg;
    assign tag_data   = out_data_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_data_next  = s1_data_reg;
        if (!line_stall)
        begin
            s1_valid_next = line_valid;
            s1_data_next  = line_data;
        end

        out_valid_next = out_valid_reg && tag_stall;
        out_data_next  = out_data_reg;
        state_next     = state_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_data_next  = step_result;
            state_next     = step_state;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= LINE_CLEAR;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_data_reg  <= s1_data_next;
        out_data_reg <= out_data_next;
    end

`ifndef NO_ASSERTIONS
    // last byte of a line leaves the state at line start
    a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_data_reg.line_end |=>
            (state_reg.phase == PH_START) && (state_reg.params_kept == '0))
        else $error("line state not cleared after line end");

    // overflow is only reached with the parameter count at its limit
    a_ovf_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.overflowed |-> (state_reg.params_kept == MAX_PARAMS))
        else $error("overflow flag without full parameter count");

    // a processed word always lands in the result register
    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> tag_valid)
        else $error("processed word lost");

    // summary fields stay zero off the line end
    a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
        tag_valid && !tag_data.line_done |->
            (tag_data.command_type == CT_UNKNOWN) && (tag_data.param_count == '0)
            && !tag_data.param_overflow)
        else $error("summary fields set before line end");
`endif

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for irc_line_tokenizer_core
// Feeds directed and random IRC message lines one byte per word, keeps its
// own model of the line tokenizer and checks every tag word in order, under
// several idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import irclt_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_BYTES   = 1850 / 4;
    localparam int SHOW_LIMIT    = 40;

    // Line tokenizer model plus the queue of tag words it has predicted.
    class tag_board;
        tag_word_t   pending_tags[$];
        int unsigned errors;
        string       keywords[10];

        logic [2:0]  phase;
        logic [31:0] conn_acc;
        logic [55:0] cmd_text;
        logic [3:0]  cmd_len;
        logic [9:0]  code_acc;
        logic [1:0]  code_digits;
        logic [3:0]  params;
        bit          at_start;
        bit          dropping;

        // tag of the byte in flight
        logic [2:0]  cls;
        logic [2:0]  role;
        bit          seg;
        logic [3:0]  pidx;

        function new();
            keywords = '{"JOIN", "KICK", "MODE", "NICK", "NOTICE",
                         "PART", "PING", "PRIVMSG", "QUIT", "TOPIC"};
            errors = 0;
            clear_line();
        endfunction

        function void clear_line();
            phase       = PH_START;
            conn_acc    = '0;
            cmd_text    = '0;
            cmd_len     = '0;
            code_acc    = '0;
            code_digits = '0;
            params      = '0;
            at_start    = 1'b1;
            dropping    = 1'b0;
        endfunction

        function bit is_num(logic [7:0] b);
            return b >= "0" && b <= "9";
        endfunction

        function bit is_blank(logic [7:0] b);
            return b == CH_SPACE || (b >= 8'd9 && b <= 8'd13);
        endfunction

        function void id_digit(logic [7:0] b);
            longint unsigned d;
            d = 64'(b) - 64'h30;
            if (64'(conn_acc) > (64'hFFFF_FFFF - d) / 10)
                conn_acc = '1;
            else
                conn_acc = 32'(64'(conn_acc) * 10 + d);
        endfunction

        function void add_cmd_byte(logic [7:0] b);
            // numeric code only from digits that lead the command
            if (code_digits == cmd_len && code_digits < 2'd3 && is_num(b))
            begin
                code_acc    = 10'(code_acc * 10 + b - 8'h30);
                code_digits = code_digits + 2'd1;
            end
            if (cmd_len < 4'd7)
                cmd_text[8*cmd_len +: 8] = b;
            if (cmd_len < 4'd15)
                cmd_len = cmd_len + 4'd1;
        endfunction

        function void cmd_step(logic [7:0] b);
            if (b == CH_SPACE)
            begin
                seg      = 1'b1;
                role     = ROLE_CMD;
                phase    = PH_PARAMS;
                at_start = 1'b1;
            end
            else
            begin
                cls = CLS_CMD;
                add_cmd_byte(b);
            end
        endfunction

        function void open_line(logic [7:0] b);
            if (b == CH_COLON)
                phase = PH_PREFIX;
            else
            begin
                phase = PH_COMMAND;
                cmd_step(b);
            end
        endfunction

        function logic [3:0] cmd_kind();
            bit same;
            if (cmd_len == 4'd0)
                return CT_UNKNOWN;
            if (is_num(cmd_text[7:0]))
                return CT_NUMERIC;
            for (int k = 0; k < 10; k++)
            begin
                if (keywords[k].len() == cmd_len)
                begin
                    same = 1'b1;
                    for (int i = 0; i < keywords[k].len(); i++)
                        if (cmd_text[8*i +: 8] != keywords[k][i])
                            same = 1'b0;
                    if (same)
                        return 4'(CT_JOIN + k);
                end
            end
            return CT_UNKNOWN;
        endfunction

        function void note_byte(logic [7:0] b, bit eol);
            tag_word_t  w;
            logic [3:0] kind;
            cls  = CLS_NONE;
            seg  = 1'b0;
            role = ROLE_NONE;
            pidx = '0;
            case (phase)
                PH_START:
                    if (b == CH_S)
                        phase = PH_CID_S;
                    else
                        open_line(b);
                PH_CID_S:
                    if (is_num(b))
                    begin
                        id_digit(b);
                        phase = PH_CID_DIGITS;
                    end
                    else
                    begin
                        // lone S is the start of the command
                        add_cmd_byte(CH_S);
                        phase = PH_COMMAND;
                        cmd_step(b);
                    end
                PH_CID_DIGITS:
                    if (is_num(b))
                        id_digit(b);
                    else if (is_blank(b))
                        phase = PH_CID_SPACE;
                    else
                        open_line(b);
                PH_CID_SPACE:
                    if (!is_blank(b))
                        open_line(b);
                PH_PREFIX:
                    if (b == CH_BANG)
                    begin
                        seg  = 1'b1;
                        role = ROLE_NICK;
                    end
                    else if (b == CH_AT)
                    begin
                        seg  = 1'b1;
                        role = ROLE_REAL;
                    end
                    else if (b == CH_SPACE)
                    begin
                        seg   = 1'b1;
                        role  = ROLE_HOST;
                        phase = PH_COMMAND;
                    end
                    else
                        cls = CLS_PREFIX;
                PH_COMMAND:
                    cmd_step(b);
                PH_PARAMS:
                    if (!dropping)
                    begin
                        // trailing text is still taken at the parameter limit
                        if (at_start && b == CH_COLON)
                            phase = PH_TEXT;
                        else if (at_start && params >= MAX_PARAMS)
                            dropping = 1'b1;
                        else if (b == CH_SPACE)
                        begin
                            seg      = 1'b1;
                            role     = ROLE_PARAM;
                            pidx     = params;
                            params   = params + 4'd1;
                            at_start = 1'b1;
                        end
                        else
                        begin
                            cls      = CLS_PARAM;
                            pidx     = params;
                            at_start = 1'b0;
                        end
                    end
                default:
                    cls = CLS_TEXT;
            endcase

            w            = '0;
            w.out_byte   = b;
            w.byte_class = cls;
            if (eol)
            begin
                if (phase == PH_COMMAND && !seg)
                begin
                    seg  = 1'b1;
                    role = ROLE_CMD;
                end
                else if (phase == PH_PARAMS && !dropping && !at_start)
                begin
                    seg    = 1'b1;
                    role   = ROLE_PARAM;
                    pidx   = params;
                    params = params + 4'd1;
                end
                else if (phase == PH_TEXT)
                begin
                    seg  = 1'b1;
                    role = ROLE_TEXT;
                end
                kind             = cmd_kind();
                w.line_done      = 1'b1;
                w.command_type   = kind;
                w.numeric_code   = (kind == CT_NUMERIC) ? code_acc : '0;
                w.conn_id        = conn_acc;
                w.param_count    = params;
                w.param_overflow = dropping;
            end
            w.segment_end  = seg;
            w.segment_role = role;
            w.param_index  = pidx;
            pending_tags.push_back(w);
            if (eol)
                clear_line();
        endfunction

        function void field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_tag(tag_word_t got);
            tag_word_t want;
            if (pending_tags.size() == 0)
            begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display("%0t: tag word with nothing expected, actual %h", $time, got);
                return;
            end
            want = pending_tags.pop_front();
            field("out_byte",       want.out_byte,       got.out_byte);
            field("byte_class",     want.byte_class,     got.byte_class);
            field("segment_end",    want.segment_end,    got.segment_end);
            field("segment_role",   want.segment_role,   got.segment_role);
            field("param_index",    want.param_index,    got.param_index);
            field("line_done",      want.line_done,      got.line_done);
            field("command_type",   want.command_type,   got.command_type);
            field("numeric_code",   want.numeric_code,   got.numeric_code);
            field("conn_id",        want.conn_id,        got.conn_id);
            field("param_count",    want.param_count,    got.param_count);
            field("param_overflow", want.param_overflow, got.param_overflow);
        endfunction
    endclass

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       line_valid = 1'b0;
    logic       line_stall;
    line_word_t line_data  = '0;
    logic       tag_valid;
    logic       tag_stall  = 1'b0;
    tag_word_t  tag_data;

    tag_board   board;
    logic [7:0] line_buf[$];
    int         send_idle_pct = 0;
    int         stall_pct     = 0;
    int         cycle_count   = 0;
    bit         in_fire       = 1'b0;
    bit         out_fire      = 1'b0;
    tag_word_t  out_word;

    irc_line_tokenizer_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_valid (line_valid),
        .line_stall (line_stall),
        .line_data  (line_data),
        .tag_valid  (tag_valid),
        .tag_stall  (tag_stall),
        .tag_data   (tag_data)
    );

    always #1 clk = ~clk;

    // Handshakes are sampled mid-cycle; inputs only move at the rising edge.
    always @(negedge clk)
    begin
        in_fire  = (line_valid === 1'b1) && (line_stall === 1'b0);
        out_fire = (tag_valid === 1'b1) && (tag_stall === 1'b0);
        out_word = tag_data;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_fire)
                board.check_tag(out_word);
            tag_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_word(input logic [7:0] b, input bit eol);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            line_valid <= 1'b0;
            @(posedge clk);
        end
        line_valid <= 1'b1;
        line_data  <= '{line_byte: b, line_end: eol};
        do
            @(posedge clk);
        while (!in_fire);
        board.note_byte(b, eol);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], i == s.len() - 1);
    endtask

    task automatic send_line();
        foreach (line_buf[i])
            send_word(line_buf[i], i == line_buf.size() - 1);
    endtask

    function automatic logic [7:0] word_char();
        if ($urandom_range(0, 15) == 0)
            return 8'($urandom);
        return 8'($urandom_range(33, 126));
    endfunction

    function automatic logic [7:0] blank_char();
        if ($urandom_range(0, 1) == 0)
            return CH_SPACE;
        return 8'($urandom_range(9, 13));
    endfunction

    function automatic void push_word(int n);
        repeat (n) line_buf.push_back(word_char());
    endfunction

    // Mostly well-formed lines with random content; some noise and cut lines.
    function automatic void make_line();
        int n;
        int k;
        line_buf.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 12);
            repeat (n) line_buf.push_back(8'($urandom));
            return;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            line_buf.push_back(CH_S);
            if ($urandom_range(0, 4) != 0)
            begin
                // long ids push the accumulator into saturation
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 14)
                                                : $urandom_range(1, 4);
                repeat (n) line_buf.push_back(8'($urandom_range(8'h30, 8'h39)));
                n = $urandom_range(0, 2);
                repeat (n) line_buf.push_back(blank_char());
            end
        end
        if ($urandom_range(0, 9) < 4)
        begin
            line_buf.push_back(CH_COLON);
            push_word($urandom_range(0, 5));
            if ($urandom_range(0, 1))
            begin
                line_buf.push_back(CH_BANG);
                push_word($urandom_range(0, 5));
            end
            if ($urandom_range(0, 1))
            begin
                line_buf.push_back(CH_AT);
                push_word($urandom_range(0, 6));
            end
            if ($urandom_range(0, 9) != 0)
                line_buf.push_back(CH_SPACE);
        end
        k = $urandom_range(0, KW_COUNT - 1);
        case ($urandom_range(0, 5))
            0, 1, 5:
            begin
                for (int i = 0; i < KW_LEN[k]; i++)
                    line_buf.push_back(KW_TEXT[k][8*i +: 8]);
                if ($urandom_range(0, 5) == 0)
                    line_buf.push_back(word_char());
            end
            2:
            begin
                n = $urandom_range(1, 5);
                repeat (n) line_buf.push_back(8'($urandom_range(8'h30, 8'h39)));
                if ($urandom_range(0, 3) == 0)
                    push_word($urandom_range(1, 3));
            end
            3:
                push_word($urandom_range(1, 10));
            default:
                ;
        endcase
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 19) : $urandom_range(0, 4);
        repeat (n)
        begin
            line_buf.push_back(CH_SPACE);
            push_word($urandom_range(0, 4));
        end
        if ($urandom_range(0, 1))
        begin
            line_buf.push_back(CH_SPACE);
            line_buf.push_back(CH_COLON);
            n = $urandom_range(0, 10);
            repeat (n)
                line_buf.push_back(($urandom_range(0, 5) == 0) ? CH_SPACE : word_char());
        end
        else if ($urandom_range(0, 7) == 0)
            line_buf.push_back(CH_SPACE);
        if ($urandom_range(0, 9) == 0 && line_buf.size() > 1)
        begin
            n = $urandom_range(1, line_buf.size() - 1);
            while (line_buf.size() > n)
                void'(line_buf.pop_back());
        end
        if (line_buf.size() == 0)
            line_buf.push_back(word_char());
    endfunction

    initial
    begin
        int idle_set[4]  = '{0, 67, 0, 30};
        int stall_set[4] = '{0, 0, 67, 30};
        int sent;
        board = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed lines: open prefix, empty command, id with numeric,
        // lone S, empty and final params, trailing text, NUL and 0xFF
        send_text(":n!r@h");
        send_text(" ");
        send_text("S4\t7");
        send_text("Sx");
        send_text("NICK  b");
        send_text("Q :t");
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b1);

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = idle_set[ph];
            stall_pct     = stall_set[ph];
            sent          = 0;
            while (sent < PHASE_BYTES)
            begin
                make_line();
                send_line();
                sent += line_buf.size();
            end
            // hold the sender off until the tokenizer has drained
            line_valid <= 1'b0;
            while (board.pending_tags.size() != 0)
                @(posedge clk);
        end

        repeat (20) @(posedge clk);
        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
